>>> hdl/rqc_pkg.sv
package rqc_pkg;

    // Field widths of the two channels
    localparam int ROT_W    = 16;
    localparam int COORD_W  = 24;
    localparam int SIZE_W   = 24;
    localparam int PIVOT_W  = 4;
    localparam int COLOR_W  = 32;

    // Internal arithmetic widths
    localparam int SIN_W          = 16;                 // Q1.15, magnitude <= 32767
    localparam int PROD_W         = SIZE_W + 1 + SIN_W; // size times sine, signed
    localparam int AXIS_W         = SIZE_W + 1;         // rounded axis step, signed
    localparam int COORD_BITS_MAX = 32;
    localparam int SUM_W          = COORD_BITS_MAX + 1; // corner sums before saturation

    localparam int ANGLE_BITS_DEF = 16;
    localparam int COORD_BITS_DEF = 24;

    localparam logic [1:0] CORNER_UL = 2'd0;
    localparam logic [1:0] CORNER_UR = 2'd1;
    localparam logic [1:0] CORNER_LL = 2'd2;
    localparam logic [1:0] CORNER_LR = 2'd3;

    typedef struct packed {
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic [SIZE_W-1:0]         width;
        logic [SIZE_W-1:0]         height;
        logic [ROT_W-1:0]          rotation;
        logic [PIVOT_W-1:0]        pivot;
        logic [COLOR_W-1:0]        color;
    } in_t;

    typedef struct packed {
        logic [1:0]                corner;
        logic signed [COORD_W-1:0] corner_x;
        logic signed [COORD_W-1:0] corner_y;
        logic                      tex_u;
        logic                      tex_v;
        logic [COLOR_W-1:0]        corner_color;
        logic                      last;
    } out_t;

    // Upper-left corner, the two axis steps and the color of one sprite
    typedef struct packed {
        logic signed [SUM_W-1:0]  ulx;
        logic signed [SUM_W-1:0]  uly;
        logic signed [AXIS_W-1:0] rx;
        logic signed [AXIS_W-1:0] ry;
        logic signed [AXIS_W-1:0] dx;
        logic signed [AXIS_W-1:0] dy;
        logic [COLOR_W-1:0]       color;
    } quad_geom_t;

endpackage

>>> hdl/rqc_sine.sv
module rqc_sine
    import rqc_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
    input  logic                    aclk,
    input  logic                    en,
    input  logic [ANGLE_BITS-1:0]   phase,
    output logic signed [SIN_W-1:0] sine
);

    localparam int FB = ANGLE_BITS - 2;
    localparam logic [11:0] SIN_C = 12'd2320;
    localparam logic [14:0] SIN_B = 15'd21024;
    localparam logic [15:0] SIN_A = 16'd51472;
    localparam logic [15:0] Z_ONE = 16'd32768;
    localparam logic [16:0] MAG_MAX = 17'd32767;

    logic [1:0]     quad;
    logic [FB-1:0]  frac;
    logic [FB+14:0] frac_ext;
    logic [14:0]    x;
    logic [15:0]    z;
    logic [31:0]    zz;

    logic [15:0] z_a_reg, z2_a_reg;
    logic        neg_a_reg;
    logic [27:0] cz;
    logic [15:0] z_b_reg, z2_b_reg;
    logic [14:0] t1_b_reg;
    logic        neg_b_reg;
    logic [30:0] tz;
    logic [15:0] z_c_reg, t2_c_reg;
    logic        neg_c_reg;
    logic [31:0] tz2;
    logic [16:0] q;
    logic [14:0] mag;
    logic signed [SIN_W-1:0] sine_reg;

    // Quadrant from the top two bits, fraction scaled to Q15 and mirrored in odd quadrants
    assign quad     = phase[ANGLE_BITS-1 -: 2];
    assign frac     = phase[FB-1:0];
    assign frac_ext = {frac, 15'd0};
    assign x        = frac_ext[FB+14 -: 15];
    assign z        = quad[0] ? (Z_ONE - {1'b0, x}) : {1'b0, x};
    assign zz       = z * z;

    always_ff @(posedge aclk) begin
        if (en) begin
            z_a_reg   <= z;
            z2_a_reg  <= zz[30:15];
            neg_a_reg <= quad[1];
        end
    end

    assign cz = SIN_C * z2_a_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            z_b_reg   <= z_a_reg;
            z2_b_reg  <= z2_a_reg;
            t1_b_reg  <= SIN_B - {2'b00, cz[27:15]};
            neg_b_reg <= neg_a_reg;
        end
    end

    assign tz = t1_b_reg * z2_b_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            z_c_reg   <= z_b_reg;
            t2_c_reg  <= SIN_A - tz[30:15];
            neg_c_reg <= neg_b_reg;
        end
    end

    assign tz2 = t2_c_reg * z_c_reg;
    assign q   = tz2[31:15];
    assign mag = (q > MAG_MAX) ? MAG_MAX[14:0] : q[14:0];

    always_ff @(posedge aclk) begin
        if (en) begin
            sine_reg <= neg_c_reg ? -signed'({1'b0, mag}) : signed'({1'b0, mag});
        end
    end

    assign sine = sine_reg;

endmodule

>>> hdl/rqc_emit.sv
module rqc_emit
    import rqc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       item_valid,
    input  quad_geom_t item,
    output logic       item_ready,
    output logic       m_valid,
    input  logic       m_ready,
    output out_t       m_data
);

    localparam logic signed [SUM_W-1:0] SAT_HI =
        SUM_W'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
    localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;
    localparam logic signed [SUM_W-1:0] ZERO_S = '0;

    logic       ser_valid_reg, ser_valid_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       out_valid_reg, out_valid_next;
    quad_geom_t geom_reg;
    out_t       out_reg;
    logic       out_load;
    logic       take;

    logic signed [SUM_W-1:0] x_sum, y_sum;

    function automatic logic [COORD_W-1:0] sat(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] r;
        if (v > SAT_HI) begin
            r = SAT_HI;
        end else if (v < SAT_LO) begin
            r = SAT_LO;
        end else begin
            r = v;
        end
        return r[COORD_W-1:0];
    endfunction

    assign out_load   = ser_valid_reg && (!out_valid_reg || m_ready);
    assign item_ready = !ser_valid_reg || (out_load && cnt_reg == CORNER_LR);
    assign take       = item_valid && item_ready;

    always_comb begin
        ser_valid_next = ser_valid_reg;
        if (take) begin
            ser_valid_next = 1'b1;
        end else if (out_load && cnt_reg == CORNER_LR) begin
            ser_valid_next = 1'b0;
        end
        cnt_next = out_load ? cnt_reg + 2'd1 : cnt_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    assign x_sum = geom_reg.ulx
                 + (cnt_reg[0] ? SUM_W'(geom_reg.rx) : ZERO_S)
                 + (cnt_reg[1] ? SUM_W'(geom_reg.dx) : ZERO_S);
    assign y_sum = geom_reg.uly
                 + (cnt_reg[0] ? SUM_W'(geom_reg.ry) : ZERO_S)
                 + (cnt_reg[1] ? SUM_W'(geom_reg.dy) : ZERO_S);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ser_valid_reg <= 1'b0;
            cnt_reg       <= CORNER_UL;
            out_valid_reg <= 1'b0;
        end else begin
            ser_valid_reg <= ser_valid_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            geom_reg <= item;
        end
        if (out_load) begin
            out_reg.corner       <= cnt_reg;
            out_reg.corner_x     <= sat(x_sum);
            out_reg.corner_y     <= sat(y_sum);
            out_reg.tex_u        <= cnt_reg[0];
            out_reg.tex_v        <= cnt_reg[1];
            out_reg.corner_color <= geom_reg.color;
            out_reg.last         <= (cnt_reg == CORNER_LR);
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    a_last_on_lr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.last |-> m_data.corner == CORNER_LR)
        else $error("last flag on a corner other than lower-right");

    a_corner_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load && cnt_reg != CORNER_LR |=> ser_valid_reg
            && cnt_reg == 2'($past(cnt_reg) + 2'd1))
        else $error("sprite dropped before its fourth corner");

    a_new_item_starts_ul: assert property (@(posedge aclk) disable iff (!aresetn)
        take |=> cnt_reg == CORNER_UL)
        else $error("new sprite does not start at the upper-left corner");

endmodule

>>> hdl/rotated_quad_corner_generator.sv
// Rotated quad corner generator.
// Input channel s_valid/s_ready/s_data carries one sprite per transaction:
// pivot position, size, rotation, anchor code and color. The result channel
// m_valid/m_ready/m_data returns four corner transactions per sprite in the
// order upper-left, upper-right, lower-left, lower-right; the fourth has last set.
// After the first corner, the other three follow on consecutive cycles when
// m_ready stays high. The single result channel emits one corner per cycle while
// m_ready is high, and a new sprite can enter while earlier ones are in flight.
// Sprites flow through an input register, a four-stage sine/cosine pipeline, a
// product stage and a rounding/offset stage into a corner sequencer; the stages
// advance together.
// When the receiver stalls, the pipeline holds in place and s_ready falls once
// the sequencer and the last stage are both occupied; nothing is dropped or
// repeated. Reset (aresetn low, synchronous) empties every stage and the output.
module rotated_quad_corner_generator
    import rqc_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    localparam int EXT_W    = ROT_W + ANGLE_BITS;
    localparam int PIPE_LEN = 6;
    localparam int DLY_LEN  = 4;

    localparam logic [1:0] ANCHOR_HALF = 2'd1;
    localparam logic [1:0] ANCHOR_FULL = 2'd2;

    localparam logic [ANGLE_BITS-1:0] QUARTER_TURN = {2'b01, {(ANGLE_BITS-2){1'b0}}};
    localparam logic signed [PROD_W-1:0] BIAS15 = PROD_W'(1 << 14);
    localparam logic signed [PROD_W-1:0] BIAS16 = PROD_W'(1 << 15);

    // {ky, kx} anchor numerators per pivot code; unknown codes act as upper-left
    localparam logic [3:0] ANCHOR_TABLE [16] = '{
        4'h0, 4'h1, 4'h2, 4'h4, 4'h5, 4'h6, 4'h8, 4'h9,
        4'hA, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0
    };

    typedef struct packed {
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic [SIZE_W-1:0]         width;
        logic [SIZE_W-1:0]         height;
        logic [1:0]                kx;
        logic [1:0]                ky;
        logic [COLOR_W-1:0]        color;
    } sprite_t;

    function automatic logic signed [AXIS_W-1:0] round15(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] t;
        t = (p + BIAS15) >>> 15;
        return t[AXIS_W-1:0];
    endfunction

    function automatic logic signed [AXIS_W-1:0] round16(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] t;
        t = (p + BIAS16) >>> 16;
        return t[AXIS_W-1:0];
    endfunction

    // Anchor fraction k/2 of a size-times-sine product
    function automatic logic signed [SUM_W-1:0] half_term(input logic [1:0] k,
                                                         input logic signed [PROD_W-1:0] p);
        logic signed [SUM_W-1:0] r;
        case (k)
            ANCHOR_HALF: r = SUM_W'(round16(p));
            ANCHOR_FULL: r = SUM_W'(round15(p));
            default:     r = '0;
        endcase
        return r;
    endfunction

    logic adv;
    logic item_ready;

    logic    s0_valid_reg;
    in_t     s0_data_reg;
    sprite_t s0_sprite;
    logic [3:0] anchor;

    logic [EXT_W-1:0]      rot_ext;
    logic [ANGLE_BITS-1:0] phase_s, phase_c;
    logic signed [SIN_W-1:0] sin_q, cos_q;

    logic [PIPE_LEN-1:0] vld_reg;
    sprite_t             dly_reg [DLY_LEN];

    logic signed [SIZE_W:0]   w_s, h_s;
    logic signed [PROD_W-1:0] p_wc_next, p_ws_next, p_hs_next, p_hc_next;
    logic signed [PROD_W-1:0] p_wc_reg, p_ws_reg, p_hs_reg, p_hc_reg;
    sprite_t                  prod_sprite_reg;

    quad_geom_t geom_next, geom_reg;

    // Whole pipeline moves together unless the last stage is held by the sequencer
    assign adv     = !vld_reg[PIPE_LEN-1] || item_ready;
    assign s_ready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_valid_reg <= 1'b0;
            vld_reg      <= '0;
        end else if (adv) begin
            s0_valid_reg <= s_valid;
            vld_reg      <= {vld_reg[PIPE_LEN-2:0], s0_valid_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && s_valid) begin
            s0_data_reg <= s_data;
        end
    end

    assign rot_ext = {s0_data_reg.rotation, {ANGLE_BITS{1'b0}}};
    assign phase_s = rot_ext[EXT_W-1 -: ANGLE_BITS];
    assign phase_c = phase_s + QUARTER_TURN;

    assign anchor          = ANCHOR_TABLE[s0_data_reg.pivot];
    assign s0_sprite.pos_x  = s0_data_reg.pos_x;
    assign s0_sprite.pos_y  = s0_data_reg.pos_y;
    assign s0_sprite.width  = s0_data_reg.width;
    assign s0_sprite.height = s0_data_reg.height;
    assign s0_sprite.kx     = anchor[1:0];
    assign s0_sprite.ky     = anchor[3:2];
    assign s0_sprite.color  = s0_data_reg.color;

    rqc_sine #(
        .ANGLE_BITS(ANGLE_BITS)
    ) u_sin (
        .aclk (aclk),
        .en   (adv),
        .phase(phase_s),
        .sine (sin_q)
    );

    rqc_sine #(
        .ANGLE_BITS(ANGLE_BITS)
    ) u_cos (
        .aclk (aclk),
        .en   (adv),
        .phase(phase_c),
        .sine (cos_q)
    );

    // Carry the sprite alongside the sine pipeline
    always_ff @(posedge aclk) begin
        if (adv) begin
            dly_reg[0] <= s0_sprite;
            for (int i = 1; i < DLY_LEN; i++) begin
                dly_reg[i] <= dly_reg[i-1];
            end
        end
    end

    assign w_s       = signed'({1'b0, dly_reg[DLY_LEN-1].width});
    assign h_s       = signed'({1'b0, dly_reg[DLY_LEN-1].height});
    assign p_wc_next = w_s * cos_q;
    assign p_ws_next = w_s * sin_q;
    assign p_hs_next = h_s * sin_q;
    assign p_hc_next = h_s * cos_q;

    always_ff @(posedge aclk) begin
        if (adv) begin
            p_wc_reg        <= p_wc_next;
            p_ws_reg        <= p_ws_next;
            p_hs_reg        <= p_hs_next;
            p_hc_reg        <= p_hc_next;
            prod_sprite_reg <= dly_reg[DLY_LEN-1];
        end
    end

    always_comb begin
        geom_next.ulx = SUM_W'(prod_sprite_reg.pos_x)
                      - half_term(prod_sprite_reg.kx, p_wc_reg)
                      + half_term(prod_sprite_reg.ky, p_hs_reg);
        geom_next.uly = SUM_W'(prod_sprite_reg.pos_y)
                      - half_term(prod_sprite_reg.kx, p_ws_reg)
                      - half_term(prod_sprite_reg.ky, p_hc_reg);
        geom_next.rx    = round15(p_wc_reg);
        geom_next.ry    = round15(p_ws_reg);
        geom_next.dx    = round15(-p_hs_reg);
        geom_next.dy    = round15(p_hc_reg);
        geom_next.color = prod_sprite_reg.color;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            geom_reg <= geom_next;
        end
    end

    rqc_emit #(
        .COORD_BITS(COORD_BITS)
    ) u_emit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .item_valid(vld_reg[PIPE_LEN-1]),
        .item      (geom_reg),
        .item_ready(item_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    a_stall_holds_last: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[PIPE_LEN-1] && !item_ready |=> vld_reg[PIPE_LEN-1] && $stable(geom_reg))
        else $error("last pipeline stage changed while the sequencer was busy");

endmodule

>>> verif/tb_rotated_quad_corner_generator.sv
`timescale 1ns / 100ps

module tb_rotated_quad_corner_generator;
    import rqc_pkg::*;

    localparam longint QS_A = 51472;
    localparam longint QS_B = 21024;
    localparam longint QS_C = 2320;
    localparam longint COORD_MAX = (longint'(1) <<< (COORD_BITS_DEF - 1)) - 1;
    localparam longint COORD_MIN = -COORD_MAX - 1;
    localparam int RANDOM_SPRITES = 100;
    localparam int TAIL_SPRITES = 20;

    typedef struct packed {
        logic drain;
        in_t  data;
    } sprite_item_t;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    in_t  s_data;
    logic m_valid;
    logic m_ready;
    out_t m_data;

    sprite_item_t sprite_queue[$];
    out_t         pending_corners[$];
    sprite_item_t next_sprite;
    out_t         want;
    bit           s_taken;
    bit           quiet_tail;
    int           tx_gap;
    int           rx_gap;
    int           fail_count;

    rotated_quad_corner_generator dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // sin(pi/2 * z), z in Q15 on [0, 32768]
    function automatic longint quarter_sine(longint z);
        longint z2;
        longint t;
        z2 = (z * z) >>> 15;
        t = (QS_C * z2) >>> 15;
        t = QS_B - t;
        t = (t * z2) >>> 15;
        t = QS_A - t;
        t = (t * z) >>> 15;
        if (t > 32767) t = 32767;
        return t;
    endfunction

    function automatic longint sine_of_turn(logic [ROT_W-1:0] ph);
        longint x;
        longint z;
        longint r;
        x = longint'({ph[ROT_W-3:0], 1'b0});
        z = ph[ROT_W-2] ? 32768 - x : x;
        r = quarter_sine(z);
        return ph[ROT_W-1] ? -r : r;
    endfunction

    // divide by 2^sh, ties toward plus infinity
    function automatic longint round_shift(longint p, int sh);
        return (p + (longint'(1) <<< (sh - 1))) >>> sh;
    endfunction

    function automatic logic [COORD_W-1:0] clamp_coord(longint v);
        longint r;
        r = v;
        if (r > COORD_MAX) r = COORD_MAX;
        else if (r < COORD_MIN) r = COORD_MIN;
        return r[COORD_W-1:0];
    endfunction

    function automatic void compute_quad_corners(in_t sp);
        logic [1:0] order [4];
        logic [1:0] cn;
        longint px, py, w, h, s, c, kx, ky;
        longint ulx, uly, rx, ry, dx, dy, x, y;
        out_t o;
        order = '{CORNER_UL, CORNER_UR, CORNER_LL, CORNER_LR};
        px = {{40{sp.pos_x[COORD_W-1]}}, sp.pos_x};
        py = {{40{sp.pos_y[COORD_W-1]}}, sp.pos_y};
        w = {40'd0, sp.width};
        h = {40'd0, sp.height};
        s = sine_of_turn(sp.rotation);
        c = sine_of_turn(sp.rotation + 16'h4000);
        kx = 0;
        ky = 0;
        // anchor codes above lower-right fall back to upper-left
        if (sp.pivot <= 4'd8) begin
            kx = longint'(sp.pivot % 3);
            ky = longint'(sp.pivot / 3);
        end
        ulx = px - round_shift(kx * w * c, 16) + round_shift(ky * h * s, 16);
        uly = py - round_shift(kx * w * s, 16) - round_shift(ky * h * c, 16);
        rx = round_shift(w * c, 15);
        ry = round_shift(w * s, 15);
        dx = round_shift(-(h * s), 15);
        dy = round_shift(h * c, 15);
        for (int k = 0; k < 4; k++) begin
            cn = order[k];
            x = ulx;
            y = uly;
            if (cn == CORNER_UR || cn == CORNER_LR) begin
                x = x + rx;
                y = y + ry;
            end
            if (cn == CORNER_LL || cn == CORNER_LR) begin
                x = x + dx;
                y = y + dy;
            end
            o.corner = cn;
            o.corner_x = clamp_coord(x);
            o.corner_y = clamp_coord(y);
            o.tex_u = cn[0];
            o.tex_v = cn[1];
            o.corner_color = sp.color;
            o.last = (cn == CORNER_LR);
            pending_corners.push_back(o);
        end
    endfunction

    function automatic sprite_item_t make_sprite(logic [23:0] px, logic [23:0] py,
                                                 logic [23:0] w, logic [23:0] h,
                                                 logic [15:0] rot, logic [3:0] pv,
                                                 logic [31:0] col);
        sprite_item_t it;
        it.drain = 1'b0;
        it.data.pos_x = px;
        it.data.pos_y = py;
        it.data.width = w;
        it.data.height = h;
        it.data.rotation = rot;
        it.data.pivot = pv;
        it.data.color = col;
        return it;
    endfunction

    // sender: hold the transaction until taken, otherwise gap or load the next sprite
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !s_taken) begin
            // hold payload
        end else if (tx_gap > 0) begin
            tx_gap--;
            s_valid <= 1'b0;
        end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
            tx_gap = $urandom_range(0, 11);
            s_valid <= 1'b0;
        end else if (sprite_queue.size() == 0 ||
                     (sprite_queue[0].drain && pending_corners.size() != 0)) begin
            s_valid <= 1'b0;
        end else begin
            next_sprite = sprite_queue.pop_front();
            s_data <= next_sprite.data;
            s_valid <= 1'b1;
            if (sprite_queue.size() <= TAIL_SPRITES) quiet_tail = 1'b1;
        end
    end

    // receiver backpressure
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            m_ready <= 1'b0;
        end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
            rx_gap = $urandom_range(0, 11);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        s_taken = aresetn && s_valid && s_ready;
        if (s_taken) compute_quad_corners(s_data);
        if (aresetn && m_valid && m_ready) begin
            if (pending_corners.size() == 0) begin
                $error("unexpected corner transaction: %p", m_data);
                fail_count++;
            end else begin
                want = pending_corners.pop_front();
                if (m_data.corner !== want.corner) begin
                    $error("corner: expected %0d, actual %0d", want.corner, m_data.corner);
                    fail_count++;
                end
                if (m_data.corner_x !== want.corner_x) begin
                    $error("corner_x: expected %h, actual %h", want.corner_x, m_data.corner_x);
                    fail_count++;
                end
                if (m_data.corner_y !== want.corner_y) begin
                    $error("corner_y: expected %h, actual %h", want.corner_y, m_data.corner_y);
                    fail_count++;
                end
                if (m_data.tex_u !== want.tex_u) begin
                    $error("tex_u: expected %b, actual %b", want.tex_u, m_data.tex_u);
                    fail_count++;
                end
                if (m_data.tex_v !== want.tex_v) begin
                    $error("tex_v: expected %b, actual %b", want.tex_v, m_data.tex_v);
                    fail_count++;
                end
                if (m_data.corner_color !== want.corner_color) begin
                    $error("corner_color: expected %h, actual %h",
                           want.corner_color, m_data.corner_color);
                    fail_count++;
                end
                if (m_data.last !== want.last) begin
                    $error("last: expected %b, actual %b", want.last, m_data.last);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        sprite_item_t it;
        logic [15:0] rots [9];
        aresetn = 1'b0;
        s_valid = 1'b0;
        m_ready = 1'b0;
        s_data = '0;
        s_taken = 1'b0;
        quiet_tail = 1'b0;
        tx_gap = 0;
        rx_gap = 0;
        fail_count = 0;

        // directed: every anchor at quadrant boundaries and odd angles
        rots = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'hFFFF,
                 16'h2000, 16'h2AAA, 16'h6001, 16'hA555};
        sprite_queue.push_back(make_sprite(24'h0, 24'h0, 24'h0, 24'h0, 16'h0, 4'd0, 32'h0));
        for (int p = 0; p < 9; p++)
            sprite_queue.push_back(make_sprite(24'h001000, 24'hFFF000, 24'h001A80, 24'h000C40,
                                               rots[p], 4'(p), 32'h80FF40C0 + p));
        // anchor codes above eight
        sprite_queue.push_back(make_sprite(24'h000500, 24'h000500, 24'h000800, 24'h000400,
                                           16'h1234, 4'd9, 32'h12345678));
        sprite_queue.push_back(make_sprite(24'h000500, 24'h000500, 24'h000800, 24'h000400,
                                           16'h1234, 4'd15, 32'h87654321));
        // saturation toward both bounds
        sprite_queue.push_back(make_sprite(24'h7FFFFF, 24'h7FFFFF, 24'hFFFFFF, 24'hFFFFFF,
                                           16'h0000, 4'd0, 32'hFFFFFFFF));
        sprite_queue.push_back(make_sprite(24'h800000, 24'h800000, 24'hFFFFFF, 24'hFFFFFF,
                                           16'h8000, 4'd0, 32'h00000000));
        sprite_queue.push_back(make_sprite(24'h7FFFFF, 24'h800000, 24'hFFFFFF, 24'hFFFFFF,
                                           16'h6000, 4'd8, 32'hAAAAAAAA));
        sprite_queue.push_back(make_sprite(24'h800000, 24'h7FFFFF, 24'hFFFFFF, 24'hFFFFFF,
                                           16'hE000, 4'd4, 32'h55555555));
        // degenerate sizes
        sprite_queue.push_back(make_sprite(24'h012345, 24'hF00001, 24'h000000, 24'h003000,
                                           16'h3000, 4'd4, 32'h01020304));
        sprite_queue.push_back(make_sprite(24'h012345, 24'hF00001, 24'h003000, 24'h000000,
                                           16'hD000, 4'd8, 32'hF0E0D0C0));
        sprite_queue.push_back(make_sprite(24'h000000, 24'h000000, 24'h000001, 24'h000001,
                                           16'h7FFF, 4'd5, 32'hFFFF0000));

        for (int n = 0; n < RANDOM_SPRITES; n++) begin
            it.drain = (n == 40 || n == 70);
            if ($urandom_range(0, 1) == 0) begin
                it.data.pos_x = 24'($urandom());
                it.data.pos_y = 24'($urandom());
            end else begin
                it.data.pos_x = 24'($signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000);
                it.data.pos_y = 24'($signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000);
            end
            if ($urandom_range(0, 7) == 0) begin
                it.data.width = 24'($urandom());
                it.data.height = 24'($urandom());
            end else begin
                it.data.width = 24'($urandom_range(0, 16'hFFFF));
                it.data.height = 24'($urandom_range(0, 16'hFFFF));
            end
            it.data.rotation = 16'($urandom());
            it.data.pivot = ($urandom_range(0, 9) != 0) ? 4'($urandom_range(0, 8))
                                                         : 4'($urandom_range(9, 15));
            it.data.color = $urandom();
            sprite_queue.push_back(it);
        end

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (sprite_queue.size() != 0 || s_valid || pending_corners.size() != 0)
            @(negedge aclk);
        repeat (16) @(posedge aclk);

        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
